FILE: rtl/length_prefixed_request_deframer_core_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// check a condition on every rising clock edge outside reset
`define LPRD_ASSERT(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define LPRD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// check that an antecedent implies a consequent in the next cycle
`define LPRD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LPRD_ASSERT(name, clk, rst_n, expr, msg)
`define LPRD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define LPRD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/lprd_pkg.sv
`default_nettype none

package lprd_pkg;

    localparam int LEN_FIELD_BYTES = 4;
    localparam int FIELD_W         = 8 * LEN_FIELD_BYTES;
    localparam int FCNT_W          = $clog2(LEN_FIELD_BYTES);
    localparam int MSG_LEN_W       = 26;
    localparam int ARG_CNT_W       = 20;
    localparam int BYTE_W          = 8;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = MSG_LEN_W;

    localparam logic [MSG_LEN_W-1:0] MAX_MSG_LEN_RST = MSG_LEN_W'(33554432);
    localparam logic [ARG_CNT_W-1:0] MAX_ARG_CNT_RST = ARG_CNT_W'(200000);

    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] ASCII_CASE_OFS = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARG_CNT = 1'b1;

    typedef enum logic [2:0] {
        PH_MSGLEN,
        PH_NARGS,
        PH_ARGLEN,
        PH_DATA,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ARG_BYTE  = 2'd0,
        KIND_EMPTY_ARG = 2'd1,
        KIND_MSG_END   = 2'd2,
        KIND_ERROR     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_MSG_TOO_BIG  = 2'd1,
        ERR_TOO_MANY     = 2'd2,
        ERR_ARG_OVERRUN  = 2'd3
    } err_t;

    typedef struct packed {
        logic [MSG_LEN_W-1:0] max_message_len;
        logic [ARG_CNT_W-1:0] max_arg_count;
    } limits_t;

    typedef struct packed {
        kind_t                kind;
        logic [BYTE_W-1:0]    arg_byte;
        logic [ARG_CNT_W-1:0] arg_index;
        logic                 last_of_arg;
        logic                 last_of_message;
        err_t                 error_code;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/lprd_parser.sv
`default_nettype none
`include "length_prefixed_request_deframer_core_macros.svh"

module lprd_parser (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          byte_valid,
    input  wire  [lprd_pkg::BYTE_W-1:0]  data_byte,
    input  lprd_pkg::limits_t            limits,
    output logic                         res_valid,
    output lprd_pkg::result_t            res
);
    import lprd_pkg::*;

    phase_t               phase_reg,       phase_next;
    logic [FCNT_W-1:0]    fcnt_reg,        fcnt_next;
    logic [FIELD_W-1:0]   shift_reg,       shift_next;
    logic [MSG_LEN_W-1:0] msg_left_reg,    msg_left_next;
    logic [ARG_CNT_W-1:0] args_left_reg,   args_left_next;
    logic [MSG_LEN_W-1:0] arg_left_reg,    arg_left_next;
    logic [ARG_CNT_W-1:0] cur_arg_reg,     cur_arg_next;
    logic                 halted_reg,      halted_next;

    logic [FIELD_W-1:0]   field_value;
    logic                 field_done;
    logic [MSG_LEN_W-1:0] msg_dec;
    logic [MSG_LEN_W-1:0] arg_dec;
    logic [ARG_CNT_W-1:0] args_dec;
    logic [BYTE_W-1:0]    low_byte;

    always_comb begin
        field_value = shift_reg;
        field_value[{fcnt_reg, 3'b000} +: BYTE_W] = data_byte;
    end

    assign field_done = (fcnt_reg == FCNT_W'(LEN_FIELD_BYTES - 1));
    assign msg_dec    = (msg_left_reg == '0) ? '0 : msg_left_reg - 1'b1;
    assign arg_dec    = (arg_left_reg == '0) ? '0 : arg_left_reg - 1'b1;
    assign args_dec   = args_left_reg - 1'b1;
    assign low_byte   = ((cur_arg_reg == '0) && (data_byte >= ASCII_UPPER_A) &&
                         (data_byte <= ASCII_UPPER_Z)) ? data_byte + ASCII_CASE_OFS : data_byte;

    always_comb begin
        phase_next     = phase_reg;
        fcnt_next      = fcnt_reg;
        shift_next     = shift_reg;
        msg_left_next  = msg_left_reg;
        args_left_next = args_left_reg;
        arg_left_next  = arg_left_reg;
        cur_arg_next   = cur_arg_reg;
        halted_next    = halted_reg;
        res_valid      = 1'b0;
        res            = '{kind: KIND_ARG_BYTE, arg_byte: '0, arg_index: '0,
                           last_of_arg: 1'b0, last_of_message: 1'b0, error_code: ERR_NONE};

        if (byte_valid && !halted_reg) begin
            case (phase_reg)
                PH_MSGLEN: begin
                    fcnt_next  = field_done ? '0 : fcnt_reg + 1'b1;
                    shift_next = field_done ? '0 : field_value;
                    if (field_done) begin
                        if (field_value > FIELD_W'(limits.max_message_len)) begin
                            halted_next    = 1'b1;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_MSG_TOO_BIG;
                        end else begin
                            msg_left_next = field_value[MSG_LEN_W-1:0];
                            cur_arg_next  = '0;
                            phase_next    = PH_NARGS;
                        end
                    end
                end
                PH_NARGS: begin
                    if (msg_left_reg == '0) begin
                        halted_next    = 1'b1;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_ARG_OVERRUN;
                    end else begin
                        msg_left_next = msg_dec;
                        fcnt_next     = field_done ? '0 : fcnt_reg + 1'b1;
                        shift_next    = field_done ? '0 : field_value;
                        if (field_done) begin
                            if (field_value > FIELD_W'(limits.max_arg_count)) begin
                                halted_next    = 1'b1;
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_TOO_MANY;
                            end else begin
                                args_left_next = field_value[ARG_CNT_W-1:0];
                                if (field_value[ARG_CNT_W-1:0] == '0) begin
                                    phase_next          = (msg_dec != '0) ? PH_SKIP : PH_MSGLEN;
                                    res_valid           = 1'b1;
                                    res.kind            = KIND_MSG_END;
                                    res.last_of_message = 1'b1;
                                end else begin
                                    phase_next = PH_ARGLEN;
                                end
                            end
                        end
                    end
                end
                PH_ARGLEN: begin
                    if (msg_left_reg == '0) begin
                        halted_next    = 1'b1;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_ARG_OVERRUN;
                    end else begin
                        msg_left_next = msg_dec;
                        fcnt_next     = field_done ? '0 : fcnt_reg + 1'b1;
                        shift_next    = field_done ? '0 : field_value;
                        if (field_done) begin
                            if (field_value > FIELD_W'(msg_dec)) begin
                                halted_next    = 1'b1;
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_ARG_OVERRUN;
                            end else begin
                                arg_left_next = field_value[MSG_LEN_W-1:0];
                                if (field_value[MSG_LEN_W-1:0] == '0) begin
                                    res_valid       = 1'b1;
                                    res.kind        = KIND_EMPTY_ARG;
                                    res.arg_index   = cur_arg_reg;
                                    res.last_of_arg = 1'b1;
                                    args_left_next  = args_dec;
                                    cur_arg_next    = cur_arg_reg + 1'b1;
                                    if (args_dec == '0) begin
                                        res.last_of_message = 1'b1;
                                        phase_next = (msg_dec != '0) ? PH_SKIP : PH_MSGLEN;
                                    end else begin
                                        phase_next = PH_ARGLEN;
                                    end
                                end else begin
                                    phase_next = PH_DATA;
                                end
                            end
                        end
                    end
                end
                PH_DATA: begin
                    msg_left_next = msg_dec;
                    arg_left_next = arg_dec;
                    res_valid     = 1'b1;
                    res.kind      = KIND_ARG_BYTE;
                    res.arg_byte  = low_byte;
                    res.arg_index = cur_arg_reg;
                    if (arg_dec == '0) begin
                        res.last_of_arg = 1'b1;
                        args_left_next  = args_dec;
                        cur_arg_next    = cur_arg_reg + 1'b1;
                        if (args_dec == '0) begin
                            res.last_of_message = 1'b1;
                            phase_next = (msg_dec != '0) ? PH_SKIP : PH_MSGLEN;
                        end else begin
                            phase_next = PH_ARGLEN;
                        end
                    end
                end
                PH_SKIP: begin
                    msg_left_next = msg_dec;
                    if (msg_dec == '0) begin
                        phase_next = PH_MSGLEN;
                    end
                end
                default: begin
                    phase_next = PH_MSGLEN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_MSGLEN;
            fcnt_reg      <= '0;
            shift_reg     <= '0;
            msg_left_reg  <= '0;
            args_left_reg <= '0;
            arg_left_reg  <= '0;
            cur_arg_reg   <= '0;
            halted_reg    <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            fcnt_reg      <= fcnt_next;
            shift_reg     <= shift_next;
            msg_left_reg  <= msg_left_next;
            args_left_reg <= args_left_next;
            arg_left_reg  <= arg_left_next;
            cur_arg_reg   <= cur_arg_next;
            halted_reg    <= halted_next;
        end
    end

    `LPRD_ASSERT_IMP(a_halted_silent, aclk, aresetn, halted_reg, !res_valid, "result while halted")
    `LPRD_ASSERT_NEXT(a_error_halts, aclk, aresetn, res_valid && (res.kind == KIND_ERROR), halted_reg, "error without halt")
    `LPRD_ASSERT_IMP(a_data_nonempty, aclk, aresetn, phase_reg == PH_DATA, arg_left_reg != '0, "data phase with empty argument")
    `LPRD_ASSERT_IMP(a_fcnt_in_field, aclk, aresetn, fcnt_reg != '0, (phase_reg == PH_MSGLEN) || (phase_reg == PH_NARGS) || (phase_reg == PH_ARGLEN), "field count outside header")

endmodule

`default_nettype wire

FILE: rtl/length_prefixed_request_deframer_core.sv
`default_nettype none
// Channel   Dir  Handshake               Payload
// s_        in   s_tvalid / s_tready     s_tdata: data_byte
// m_        out  m_tvalid / m_tready     m_tdata, m_tlast, m_tuser
// cfg_      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per cycle while s_tready is high; a byte's result, if any, appears the cycle after it.
// The parser state updates in one pass from the accepted byte; the result register
// is the only stage. s_tready drops only while a result waits and m_tready is low.
// aresetn is synchronous; limits return to their defaults, no clearing pass needed.
// cfg_ready is always high.

module length_prefixed_request_deframer_core (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [lprd_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [7:0] arg_byte, [27:8] arg_index, [28] last_of_arg, [30:29] error_code, [31] zero
    output logic [lprd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast,   // last_of_message
    output logic [lprd_pkg::M_TUSER_W-1:0]   m_tuser,   // [1:0] kind
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [lprd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [lprd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lprd_pkg::*;

    limits_t limits_reg, limits_next;
    logic    m_valid_reg, m_valid_next;
    result_t out_reg, out_next;

    logic    s_accept;
    logic    res_valid;
    result_t res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    lprd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_accept),
        .data_byte  (s_tdata[BYTE_W-1:0]),
        .limits     (limits_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb begin
        limits_next = limits_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAX_MSG_LEN: limits_next.max_message_len = cfg_data[MSG_LEN_W-1:0];
                CFG_MAX_ARG_CNT: limits_next.max_arg_count   = cfg_data[ARG_CNT_W-1:0];
                default: limits_next = limits_reg;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (s_accept) begin
            m_valid_next = res_valid;
            out_next     = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg  <= '{max_message_len: MAX_MSG_LEN_RST, max_arg_count: MAX_ARG_CNT_RST};
            m_valid_reg <= 1'b0;
        end else begin
            limits_reg  <= limits_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_reg.error_code, out_reg.last_of_arg,
                       out_reg.arg_index, out_reg.arg_byte};
    assign m_tlast  = out_reg.last_of_message;
    assign m_tuser  = out_reg.kind;

endmodule

`default_nettype wire
